// File: rtl/rrts_pkg.sv
`timescale 1ns / 1ps
package rrts_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE    = 3'd0,
    CMD_SCHEDULE  = 3'd1,
    CMD_BLOCK     = 3'd2,
    CMD_UNBLOCK   = 3'd3,
    CMD_EXIT      = 3'd4,
    CMD_TERMINATE = 3'd5,
    CMD_REAP      = 3'd6,
    CMD_WAIT_ANY  = 3'd7
  } cmd_code_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_NO_READY = 3'd2,
    STS_LAST     = 3'd3,
    STS_WAITING  = 3'd4,
    STS_NO_CHILD = 3'd5,
    STS_BAD_SLOT = 3'd6
  } status_code_t;

  typedef enum logic [1:0] {
    SL_FREE    = 2'd0,
    SL_READY   = 2'd1,
    SL_BLOCKED = 2'd2,
    SL_ZOMBIE  = 2'd3
  } slot_state_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_WALK,
    CS_SCAN,
    CS_DONE
  } ctl_state_t;

  localparam logic [15:0] NO_CHILD_ID = 16'hFFFF;

  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         task_slot;
    logic signed [31:0] exit_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         current_slot;
    logic               switched;
    logic [3:0]         result_slot;
    logic [15:0]        result_id;
    logic signed [31:0] result_code;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic scan;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_walk;
    logic need_scan;
    logic walk_end;
    logic scan_end;
    logic scan_walk;
    logic out_busy;
  } dp_sts_t;

endpackage

// File: rtl/rrts_ctrl.sv
`timescale 1ns / 1ps
module rrts_ctrl import rrts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_EXEC;
      end
      CS_EXEC: begin
        if (sts.need_scan) state_nxt = CS_SCAN;
        else if (sts.need_walk) state_nxt = CS_WALK;
        else state_nxt = CS_DONE;
      end
      CS_WALK: begin
        if (sts.walk_end) state_nxt = CS_DONE;
      end
      CS_SCAN: begin
        if (sts.scan_end) state_nxt = sts.scan_walk ? CS_WALK : CS_DONE;
      end
      CS_DONE: begin
        if (!sts.out_busy) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != CS_IDLE);
    cmd      = '0;
    case (state_r)
      CS_IDLE: cmd.load = in_valid;
      CS_EXEC: cmd.exec = 1'b1;
      CS_WALK: cmd.walk = 1'b1;
      CS_SCAN: cmd.scan = 1'b1;
      CS_DONE: cmd.emit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/rrts_dp.sv
`timescale 1ns / 1ps
module rrts_dp import rrts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int KW = $clog2(MAX_TASKS + 1);

  slot_state_t st_r  [MAX_TASKS];
  logic [SW-1:0] nxt_r [MAX_TASKS];
  logic [SW-1:0] prv_r [MAX_TASKS];
  logic [SW-1:0] par_r [MAX_TASKS];
  logic          pv_r  [MAX_TASKS];
  logic [15:0]   idn_r [MAX_TASKS];
  logic [31:0]   ex_r  [MAX_TASKS];

  logic          enable_r;
  logic [SW-1:0] run_r, before_r;
  logic [KW-1:0] live_r;
  logic [15:0]   idc_r;

  logic [2:0]         cmd_r;
  logic [3:0]         tgt_r;
  logic signed [31:0] code_r;

  logic [SW-1:0] rslot_r;
  logic [15:0]   rid_r;
  logic [31:0]   rcode_r;
  logic [2:0]    stat_r;
  logic          wait_r;

  logic [SW-1:0] n_r;
  logic [KW-1:0] k_r;
  logic          any_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic [SW-1:0] tgt_i;
  logic          tgt_ok;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          exit_like;
  logic          cr_en, blk_en, ub_en, mz_en, ul_en;
  logic [SW-1:0] mz_s, ul_s;
  logic [2:0]    exec_status;
  logic          exec_wait;
  logic          k_max;
  logic          scan_hit, scan_found;

  assign tgt_i  = SW'(tgt_r);
  assign tgt_ok = (32'(tgt_r) < 32'(MAX_TASKS)) && (st_r[tgt_i] != SL_FREE);
  assign k_max  = (k_r == KW'(MAX_TASKS));
  assign exit_like = (cmd_r == CMD_EXIT) ||
                     ((cmd_r == CMD_TERMINATE) && tgt_ok && (tgt_i == run_r));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (st_r[i] == SL_FREE) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign scan_hit   = pv_r[n_r] && (par_r[n_r] == run_r);
  assign scan_found = (n_r != run_r) && !k_max && scan_hit && (st_r[n_r] == SL_ZOMBIE);

  always_comb begin
    cr_en = 1'b0; blk_en = 1'b0; ub_en = 1'b0; mz_en = 1'b0; ul_en = 1'b0;
    mz_s = run_r; ul_s = tgt_i;
    exec_status = STS_OK;
    exec_wait   = 1'b0;
    sts = '0;
    if (cmd.exec) begin
      case (cmd_r)
        CMD_CREATE: begin
          if (free_found) cr_en = 1'b1;
          else exec_status = STS_FULL;
        end
        CMD_SCHEDULE: sts.need_walk = enable_r;
        CMD_BLOCK: begin
          blk_en = 1'b1;
          sts.need_walk = enable_r;
        end
        CMD_UNBLOCK: begin
          if (!tgt_ok) exec_status = STS_BAD_SLOT;
          else ub_en = (st_r[tgt_i] == SL_BLOCKED);
        end
        CMD_EXIT, CMD_TERMINATE: begin
          if (!exit_like && !tgt_ok) begin
            exec_status = STS_BAD_SLOT;
          end else begin
            mz_en = 1'b1;
            mz_s  = exit_like ? run_r : tgt_i;
            if (exit_like) begin
              if (live_r <= KW'(1)) exec_status = STS_LAST;
              else sts.need_walk = enable_r;
            end
          end
        end
        CMD_REAP: begin
          if (!tgt_ok || tgt_i == run_r) begin
            exec_status = STS_BAD_SLOT;
          end else if (st_r[tgt_i] == SL_ZOMBIE) begin
            ul_en = 1'b1;
          end else begin
            blk_en        = 1'b1;
            exec_status   = STS_WAITING;
            exec_wait     = 1'b1;
            sts.need_walk = enable_r;
          end
        end
        CMD_WAIT_ANY: sts.need_scan = 1'b1;
        default: exec_status = STS_OK;
      endcase
    end
    sts.walk_end  = (n_r == run_r) || (st_r[n_r] == SL_READY) || k_max;
    sts.scan_end  = (n_r == run_r) || k_max || scan_found;
    sts.scan_walk = sts.scan_end && !scan_found && any_r && enable_r;
    sts.out_busy  = out_valid_r && out_stall;
    if (cmd.scan && scan_found) begin
      ul_en = 1'b1;
      ul_s  = n_r;
    end
    if (cmd.scan && sts.scan_end && !scan_found && any_r) blk_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        st_r[i]  <= SL_FREE;
        nxt_r[i] <= SW'(i);
        prv_r[i] <= SW'(i);
        pv_r[i]  <= 1'b0;
        idn_r[i] <= '0;
      end
      st_r[0]     <= SL_READY;
      run_r       <= '0;
      live_r      <= KW'(1);
      idc_r       <= 16'd1;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) enable_r <= cfg_wdata;

      if (cmd.load) begin
        cmd_r    <= in_item.command;
        tgt_r    <= in_item.task_slot;
        code_r   <= in_item.exit_value;
        before_r <= run_r;
        rslot_r  <= '0;
        rid_r    <= '0;
        rcode_r  <= '0;
        stat_r   <= STS_OK;
        wait_r   <= 1'b0;
      end

      if (cmd.exec) begin
        n_r    <= nxt_r[run_r];
        k_r    <= '0;
        any_r  <= 1'b0;
        stat_r <= exec_status;
        wait_r <= exec_wait;
      end

      if (cr_en) begin
        st_r[free_idx]         <= SL_READY;
        par_r[free_idx]        <= run_r;
        pv_r[free_idx]         <= 1'b1;
        idn_r[free_idx]        <= idc_r;
        ex_r[free_idx]         <= '0;
        nxt_r[free_idx]        <= nxt_r[run_r];
        prv_r[free_idx]        <= run_r;
        prv_r[nxt_r[run_r]]    <= free_idx;
        nxt_r[run_r]           <= free_idx;
        idc_r                  <= idc_r + 16'd1;
        live_r                 <= live_r + KW'(1);
        rslot_r                <= free_idx;
        rid_r                  <= idc_r;
      end

      if (blk_en) st_r[run_r] <= SL_BLOCKED;
      if (ub_en) st_r[tgt_i] <= SL_READY;

      if (mz_en) begin
        st_r[mz_s] <= SL_ZOMBIE;
        ex_r[mz_s] <= code_r;
        if (pv_r[mz_s] && st_r[par_r[mz_s]] == SL_BLOCKED) st_r[par_r[mz_s]] <= SL_READY;
      end

      if (ul_en) begin
        rslot_r             <= ul_s;
        rid_r               <= idn_r[ul_s];
        rcode_r             <= ex_r[ul_s];
        nxt_r[prv_r[ul_s]]  <= nxt_r[ul_s];
        prv_r[nxt_r[ul_s]]  <= prv_r[ul_s];
        nxt_r[ul_s]         <= ul_s;
        prv_r[ul_s]         <= ul_s;
        st_r[ul_s]          <= SL_FREE;
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (pv_r[i] && par_r[i] == ul_s) pv_r[i] <= 1'b0;
        end
        pv_r[ul_s] <= 1'b0;
        if (live_r != '0) live_r <= live_r - KW'(1);
      end

      if (cmd.walk) begin
        if (sts.walk_end) begin
          if (n_r != run_r && st_r[n_r] == SL_READY) run_r <= n_r;
          else if (st_r[run_r] != SL_READY && !wait_r) stat_r <= STS_NO_READY;
        end else begin
          n_r <= nxt_r[n_r];
          k_r <= k_r + KW'(1);
        end
      end

      if (cmd.scan && !scan_found) begin
        if (sts.scan_end) begin
          if (!any_r) begin
            stat_r <= STS_NO_CHILD;
            rid_r  <= NO_CHILD_ID;
          end else begin
            stat_r <= STS_WAITING;
            wait_r <= 1'b1;
            n_r    <= nxt_r[run_r];
            k_r    <= '0;
          end
        end else begin
          any_r <= any_r | scan_hit;
          n_r   <= nxt_r[n_r];
          k_r   <= k_r + KW'(1);
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.current_slot <= 4'(run_r);
      out_r.switched     <= (run_r != before_r);
      out_r.result_slot  <= 4'(rslot_r);
      out_r.result_id    <= rid_r;
      out_r.result_code  <= rcode_r;
      out_r.status       <= stat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_live_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    live_r != '0) else $error("live task count dropped to zero");
  a_run_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    st_r[run_r] != SL_FREE) else $error("running slot is free");
  a_ring_link: assert property (@(posedge clk) disable iff (!rst_n)
    prv_r[nxt_r[run_r]] == run_r) else $error("ring links broken at running slot");
  a_last_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == STS_LAST |-> !out_r.switched)
    else $error("switch reported with last task halted");
`endif

endmodule

// File: rtl/round_robin_task_scheduler.sv
`timescale 1ns / 1ps
// round-robin task scheduler: slot table joined in a circular doubly linked ring
// input channel (in_valid/in_stall/in_item): one command item, taken when
//   in_valid is high and in_stall is low; in_stall stays high while a command
//   is in progress
// output channel (out_valid/out_stall/out_item): one result item per command,
//   held in an output register until taken; a new command can be accepted
//   while the previous result is still waiting
// cfg port: cfg_we writes cfg_wdata into the scheduling enable register
// command steps: accept, execute, then the schedule walk and the wait-any
//   child scan over the ring entries, then load of the result register
// the ring walk visits one slot per cycle
// reset: slot zero ready and running, every other slot free, scheduling
//   disabled, no result pending
// a stalled receiver holds the result; the block finishes the next command
//   and waits in its done state until the output register frees up
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // command and status between sequencer and slot table
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencer: execute, ring walk, child scan, result hand-off
  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  // slot table, ring pointers and result register
  rrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
